FILE: rtl/sepf_pkg.sv
// Shared constants, types and register codes of the scan-line edge point finder.
`default_nettype none

package sepf_pkg;

    // Fixed geometry of the block.
    localparam int LANES           = 8;
    localparam int MAX_HALF_LENGTH = 8;
    localparam int LINE_LENGTH     = 2048;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int BLUR_W     = 4;
    localparam int HALF_CFG_W = 4;
    localparam int THR_W      = 8;
    localparam int DEPTH_W    = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    // Derived widths.
    localparam int PIX_MAX     = (2 ** PIX_W) - 1;
    localparam int WIN_DEPTH   = 2 * MAX_HALF_LENGTH + 1;
    localparam int SUM_W       = $clog2(LANES * PIX_MAX + 1);
    localparam int DIFF_W      = $clog2(MAX_HALF_LENGTH * LANES * PIX_MAX + 1) + 1;
    localparam int POS_W       = $clog2(LINE_LENGTH);
    localparam int LANE_CNT_W  = $clog2(LANES + 1);
    localparam int HALF_W      = $clog2(MAX_HALF_LENGTH + 1);
    localparam int KTW_W       = THR_W + LANE_CNT_W;
    localparam int K_W         = THR_W + LANE_CNT_W + HALF_W;
    localparam int CMP_W       = ((DIFF_W > K_W) ? DIFF_W : K_W) + 2;
    localparam int TAP_IDX_W   = $clog2(WIN_DEPTH + 1);
    localparam int POSCMP_W    = POS_W + HALF_W + 1;

    // The tap weighting is summed in groups, one registered partial sum each.
    localparam int GROUP       = 6;
    localparam int NGROUPS     = (WIN_DEPTH + GROUP - 1) / GROUP;

    // Reset values of the configuration registers.
    localparam logic [BLUR_W-1:0]     BLUR_RST   = BLUR_W'(5);
    localparam logic [HALF_CFG_W-1:0] HALF_RST   = HALF_CFG_W'(2);
    localparam logic [THR_W-1:0]      THR_RST    = THR_W'(20);
    localparam logic [DEPTH_W-1:0]    DEPTH_RST  = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLUR_WIDTH     = 3'd0,
        REG_HALF_LENGTH    = 3'd1,
        REG_EDGE_THRESHOLD = 3'd2,
        REG_SELECT_FIRST   = 3'd3,
        REG_LIGHT_TO_DARK  = 3'd4,
        REG_DEPTH_LIMIT    = 3'd5
    } cfg_reg_t;

    // Configuration as seen by the datapath, with the counts already clamped.
    typedef struct packed {
        logic [LANE_CNT_W-1:0] width;
        logic [HALF_W-1:0]     half;
        logic                  select_first;
        logic                  light_to_dark;
        logic [DEPTH_W-1:0]    depth;
        logic [K_W-1:0]        k;
    } cfg_t;

    // Control that travels with each position through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             elig;
        logic [POS_W-1:0] center;
    } item_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/scanline_edge_point_finder_unit.sv
// Top level of the scan-line edge point finder: configuration, line position and pipeline.
`default_nettype none

// Channel   Beat                                   Handshake
// --------  -------------------------------------  ---------------------
// input     pixel_0..pixel_7, last_in_line         in_valid / in_ready
// output    found, edge_position, edge_strength    out_valid / out_ready
// config    cfg_index, cfg_data                    cfg_valid / cfg_ready
//
// One position is accepted per clock. A position passes through five register
// stages: lane sum, window shift, grouped partial sums, difference and the
// decision stage with its result register. The lane sum is captured at the
// accepting edge; a line's result then passes through the window, partial sum,
// difference and result registers. Reset clears all control and line state at
// once; no clearing pass is needed. The input side stalls only when the last
// position of a line reaches the decision stage while the previous result has
// still not been taken. Configuration beats are always accepted; a threshold
// change takes effect through the k_tw and k product registers.

module scanline_edge_point_finder_unit (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        in_valid,
    output logic                                       in_ready,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_0,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_1,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_2,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_3,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_4,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_5,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_6,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixel_7,
    input  wire                                        last_in_line,
    output logic                                       out_valid,
    input  wire                                        out_ready,
    output logic                                       found,
    output logic [sepf_pkg::POS_W-1:0]                 edge_position,
    output logic signed [sepf_pkg::DIFF_W-1:0]         edge_strength,
    input  wire                                        cfg_valid,
    output logic                                       cfg_ready,
    input  wire  [sepf_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  wire  [sepf_pkg::CFG_DATA_W-1:0]            cfg_data
);
    import sepf_pkg::*;

    logic [BLUR_W-1:0]     blur_width_reg;
    logic [HALF_CFG_W-1:0] half_length_reg;
    logic [THR_W-1:0]      threshold_reg;
    logic                  select_first_reg;
    logic                  light_to_dark_reg;
    logic [DEPTH_W-1:0]    depth_limit_reg;
    logic [KTW_W-1:0]      k_tw_reg;
    logic [K_W-1:0]        k_reg;
    logic [POS_W-1:0]      line_pos_reg;
    logic [POS_W-1:0]      line_pos_next;

    logic [LANE_CNT_W-1:0] width_clamped;
    logic [HALF_W-1:0]     half_clamped;
    cfg_t                  cfg;
    item_ctl_t             ctl_in;
    item_ctl_t             ctl_lane;
    item_ctl_t             ctl_diff;
    logic [PIX_W-1:0]      pixels [LANES];
    logic [SUM_W-1:0]      lane_sum;
    logic signed [DIFF_W-1:0] diff;
    logic                  advance;
    logic                  in_fire;
    logic                  cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = advance;
    assign in_fire   = in_valid && in_ready;

    // Register file. Out-of-range indices are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_width_reg    <= BLUR_RST;
            half_length_reg   <= HALF_RST;
            threshold_reg     <= THR_RST;
            select_first_reg  <= 1'b0;
            light_to_dark_reg <= 1'b0;
            depth_limit_reg   <= DEPTH_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_BLUR_WIDTH:     blur_width_reg    <= cfg_data[BLUR_W-1:0];
                REG_HALF_LENGTH:    half_length_reg   <= cfg_data[HALF_CFG_W-1:0];
                REG_EDGE_THRESHOLD: threshold_reg     <= cfg_data[THR_W-1:0];
                REG_SELECT_FIRST:   select_first_reg  <= cfg_data[0];
                REG_LIGHT_TO_DARK:  light_to_dark_reg <= cfg_data[0];
                REG_DEPTH_LIMIT:    depth_limit_reg   <= cfg_data[DEPTH_W-1:0];
                default:            ;
            endcase
        end
    end

    // A width or half length of zero counts as one; values above the
    // hardware limits are held at those limits.
    always_comb
    begin
        if (blur_width_reg == '0)
        begin
            width_clamped = LANE_CNT_W'(1);
        end
        else if (32'(blur_width_reg) > LANES)
        begin
            width_clamped = LANE_CNT_W'(LANES);
        end
        else
        begin
            width_clamped = LANE_CNT_W'(blur_width_reg);
        end

        if (half_length_reg == '0)
        begin
            half_clamped = HALF_W'(1);
        end
        else if (32'(half_length_reg) > MAX_HALF_LENGTH)
        begin
            half_clamped = HALF_W'(MAX_HALF_LENGTH);
        end
        else
        begin
            half_clamped = HALF_W'(half_length_reg);
        end
    end

    // Threshold scaled by width and half length, so the comparison against
    // the raw difference sum is exact. Two registered products.
    always_ff @(posedge clk)
    begin
        k_tw_reg <= KTW_W'(threshold_reg) * KTW_W'(width_clamped);
        k_reg    <= K_W'(k_tw_reg) * K_W'(half_clamped);
    end

    assign cfg.width         = width_clamped;
    assign cfg.half          = half_clamped;
    assign cfg.select_first  = select_first_reg;
    assign cfg.light_to_dark = light_to_dark_reg;
    assign cfg.depth         = depth_limit_reg;
    assign cfg.k             = k_reg;

    // Line position counts accepted beats, saturating near the line limit,
    // and restarts after the last beat of a line.
    always_comb
    begin
        line_pos_next = line_pos_reg;
        if (in_fire)
        begin
            if (last_in_line)
            begin
                line_pos_next = '0;
            end
            else if (32'(line_pos_reg) < LINE_LENGTH - 1)
            begin
                line_pos_next = line_pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg <= '0;
        end
        else
        begin
            line_pos_reg <= line_pos_next;
        end
    end

    // The filter centre trails the newest position by the half length; it
    // is only evaluated once the full window lies inside the line.
    assign ctl_in.valid  = in_valid;
    assign ctl_in.last   = last_in_line;
    assign ctl_in.elig   = POSCMP_W'(line_pos_reg) >= (POSCMP_W'(half_clamped) << 1);
    assign ctl_in.center = line_pos_reg - POS_W'(half_clamped);

    assign pixels[0] = pixel_0;
    assign pixels[1] = pixel_1;
    assign pixels[2] = pixel_2;
    assign pixels[3] = pixel_3;
    assign pixels[4] = pixel_4;
    assign pixels[5] = pixel_5;
    assign pixels[6] = pixel_6;
    assign pixels[7] = pixel_7;

    sepf_lanes u_lanes (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .pixels  (pixels),
        .ctl_in  (ctl_in),
        .ctl_out (ctl_lane),
        .sum_out (lane_sum)
    );

    sepf_diff_filter u_diff_filter (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cfg      (cfg),
        .ctl_in   (ctl_lane),
        .sum_in   (lane_sum),
        .ctl_out  (ctl_diff),
        .diff_out (diff)
    );

    sepf_edge_select u_edge_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .ctl           (ctl_diff),
        .diff          (diff),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .edge_position (edge_position),
        .edge_strength (edge_strength)
    );

endmodule

`default_nettype wire

FILE: rtl/sepf_lanes.sv
// Parallel pixel lanes and the merging adder that forms the lane sum.
`default_nettype none

module sepf_lanes (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        advance,
    input  wire  sepf_pkg::cfg_t                       cfg,
    input  wire  [sepf_pkg::PIX_W-1:0]                 pixels [sepf_pkg::LANES],
    input  wire  sepf_pkg::item_ctl_t                  ctl_in,
    output sepf_pkg::item_ctl_t                        ctl_out,
    output logic [sepf_pkg::SUM_W-1:0]                 sum_out
);
    import sepf_pkg::*;

    logic [SUM_W-1:0] lane_val [LANES];
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    item_ctl_t        ctl_reg;

    // Each lane passes its pixel only when it lies within the blur width.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign lane_val[g] = (LANE_CNT_W'(g) < cfg.width) ? SUM_W'(pixels[g]) : '0;
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_next = sum_next + lane_val[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire

FILE: rtl/sepf_diff_filter.sv
// Lane sum window and the pipelined difference filter over it.
`default_nettype none

module sepf_diff_filter (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        advance,
    input  wire  sepf_pkg::cfg_t                       cfg,
    input  wire  sepf_pkg::item_ctl_t                  ctl_in,
    input  wire  [sepf_pkg::SUM_W-1:0]                 sum_in,
    output sepf_pkg::item_ctl_t                        ctl_out,
    output logic signed [sepf_pkg::DIFF_W-1:0]         diff_out
);
    import sepf_pkg::*;

    logic [SUM_W-1:0]         win_reg  [WIN_DEPTH];
    logic signed [DIFF_W-1:0] term     [WIN_DEPTH];
    logic signed [DIFF_W-1:0] part_next [NGROUPS];
    logic signed [DIFF_W-1:0] part_reg  [NGROUPS];
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [TAP_IDX_W-1:0]     h_ext;
    logic [TAP_IDX_W-1:0]     h2_ext;
    item_ctl_t                ctl2_reg;
    item_ctl_t                ctl3_reg;
    item_ctl_t                ctl4_reg;

    assign h_ext  = TAP_IDX_W'(cfg.half);
    assign h2_ext = h_ext << 1;

    // Newest lane sum sits in tap zero. Only taps up to twice the half length
    // are ever weighted, and those always belong to the current line.
    always_ff @(posedge clk)
    begin
        if (advance && ctl_in.valid)
        begin
            win_reg[0] <= sum_in;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // Taps ahead of the centre add, taps behind it subtract.
    for (genvar t = 0; t < WIN_DEPTH; t++) begin : g_tap
        always_comb
        begin
            if (TAP_IDX_W'(t) < h_ext)
            begin
                term[t] = signed'(DIFF_W'(win_reg[t]));
            end
            else if ((TAP_IDX_W'(t) > h_ext) && (TAP_IDX_W'(t) <= h2_ext))
            begin
                term[t] = -signed'(DIFF_W'(win_reg[t]));
            end
            else
            begin
                term[t] = '0;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < WIN_DEPTH)
                begin
                    part_next[g] = part_next[g] + term[g * GROUP + j];
                end
            end
        end
    end

    always_comb
    begin
        diff_next = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            diff_next = diff_next + part_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (advance)
        begin
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int g = 0; g < NGROUPS; g++)
            begin
                part_reg[g] <= part_next[g];
            end
            diff_reg <= diff_next;
        end
    end

    assign ctl_out  = ctl4_reg;
    assign diff_out = diff_reg;

endmodule

`default_nettype wire

FILE: rtl/sepf_edge_select.sv
// Edge selection (peak or first mode), per-line state and the result register.
`default_nettype none

module sepf_edge_select (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire  sepf_pkg::cfg_t                       cfg,
    input  wire  sepf_pkg::item_ctl_t                  ctl,
    input  wire signed [sepf_pkg::DIFF_W-1:0]          diff,
    output logic                                       advance,
    output logic                                       out_valid,
    input  wire                                        out_ready,
    output logic                                       found,
    output logic [sepf_pkg::POS_W-1:0]                 edge_position,
    output logic signed [sepf_pkg::DIFF_W-1:0]         edge_strength
);
    import sepf_pkg::*;

    logic                     have_reg,      have_next;
    logic                     pend_reg,      pend_next;
    logic                     settled_reg,   settled_next;
    logic [DEPTH_W-1:0]       count_reg,     count_next;
    logic signed [DIFF_W-1:0] best_str_reg,  best_str_next;
    logic [POS_W-1:0]         best_pos_reg,  best_pos_next;
    logic signed [DIFF_W-1:0] pend_str_reg,  pend_str_next;
    logic [POS_W-1:0]         pend_pos_reg,  pend_pos_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg,     found_next;
    logic [POS_W-1:0]         opos_reg,      opos_next;
    logic signed [DIFF_W-1:0] ostr_reg,      ostr_next;

    logic                     take;
    logic signed [CMP_W-1:0]  dx;
    logic signed [CMP_W-1:0]  bx;
    logic signed [CMP_W-1:0]  s;
    logic signed [CMP_W-1:0]  bs;
    logic signed [CMP_W-1:0]  kx;
    logic signed [CMP_W-1:0]  neg_kx;
    logic [DEPTH_W-1:0]       count_dec;

    // Only a line end that finds the result register full holds the pipeline.
    assign advance = !(ctl.valid && ctl.last && out_valid_reg && !out_ready);
    assign take    = ctl.valid && advance;

    assign dx        = {{(CMP_W-DIFF_W){diff[DIFF_W-1]}}, diff};
    assign bx        = {{(CMP_W-DIFF_W){best_str_reg[DIFF_W-1]}}, best_str_reg};
    assign s         = cfg.light_to_dark ? -dx : dx;
    assign bs        = cfg.light_to_dark ? -bx : bx;
    assign kx        = signed'({{(CMP_W-K_W){1'b0}}, cfg.k});
    assign neg_kx    = -kx;
    assign count_dec = count_reg - DEPTH_W'(1);

    always_comb
    begin
        have_next      = have_reg;
        pend_next      = pend_reg;
        settled_next   = settled_reg;
        count_next     = count_reg;
        best_str_next  = best_str_reg;
        best_pos_next  = best_pos_reg;
        pend_str_next  = pend_str_reg;
        pend_pos_next  = pend_pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        opos_next      = opos_reg;
        ostr_next      = ostr_reg;

        if (take && ctl.elig)
        begin
            if (!cfg.select_first)
            begin
                if ((s > bs) && (s > signed'(CMP_W'(0))) && (s >= kx))
                begin
                    best_str_next = diff;
                    best_pos_next = ctl.center;
                    have_next     = 1'b1;
                end
            end
            else if (!settled_reg)
            begin
                if (pend_reg)
                begin
                    if (s < neg_kx)
                    begin
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            settled_next  = 1'b1;
                            have_next     = 1'b1;
                            best_pos_next = pend_pos_reg;
                            best_str_next = pend_str_reg;
                            pend_next     = 1'b0;
                        end
                    end
                end
                else if (s > kx)
                begin
                    if (cfg.depth == '0)
                    begin
                        settled_next  = 1'b1;
                        have_next     = 1'b1;
                        best_pos_next = ctl.center;
                        best_str_next = diff;
                    end
                    else
                    begin
                        pend_next     = 1'b1;
                        pend_pos_next = ctl.center;
                        pend_str_next = diff;
                        count_next    = cfg.depth;
                    end
                end
            end
        end

        if (take && ctl.last)
        begin
            // A candidate still in its lookahead at line end is accepted.
            if (pend_next && !settled_next)
            begin
                have_next     = 1'b1;
                best_pos_next = pend_pos_next;
                best_str_next = pend_str_next;
            end
            out_valid_next = 1'b1;
            found_next     = have_next;
            opos_next      = have_next ? best_pos_next : '0;
            ostr_next      = have_next ? best_str_next : '0;

            have_next      = 1'b0;
            pend_next      = 1'b0;
            settled_next   = 1'b0;
            count_next     = '0;
            best_str_next  = '0;
            best_pos_next  = '0;
            pend_str_next  = '0;
            pend_pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            settled_reg   <= 1'b0;
            count_reg     <= '0;
            best_str_reg  <= '0;
            best_pos_reg  <= '0;
            pend_str_reg  <= '0;
            pend_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            pend_reg      <= pend_next;
            settled_reg   <= settled_next;
            count_reg     <= count_next;
            best_str_reg  <= best_str_next;
            best_pos_reg  <= best_pos_next;
            pend_str_reg  <= pend_str_next;
            pend_pos_reg  <= pend_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        opos_reg  <= opos_next;
        ostr_reg  <= ostr_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign edge_position = opos_reg;
    assign edge_strength = ostr_reg;

endmodule

`default_nettype wire

FILE: bench/edge_report_checker.sv
// Checker for the scan-line edge point finder: predicts each line's report and compares it.
`timescale 1ns / 1ps

module edge_report_checker (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    input  wire                                   in_ready,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_0,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_1,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_2,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_3,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_4,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_5,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_6,
    input  wire  [sepf_pkg::PIX_W-1:0]            pixel_7,
    input  wire                                   last_in_line,
    input  wire                                   out_valid,
    input  wire                                   out_ready,
    input  wire                                   found,
    input  wire  [sepf_pkg::POS_W-1:0]            edge_position,
    input  wire  signed [sepf_pkg::DIFF_W-1:0]    edge_strength,
    input  wire                                   cfg_valid,
    input  wire                                   cfg_ready,
    input  wire  [sepf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [sepf_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    results_owed,
    output int                                    mismatches,
    output int                                    edges_reported
);
    import sepf_pkg::*;

    typedef struct {
        logic                     found;
        logic [POS_W-1:0]         position;
        logic signed [DIFF_W-1:0] strength;
    } edge_report_t;

    edge_report_t owed_reports[$];

    // Register copy.
    logic [BLUR_W-1:0]     blur_width;
    logic [HALF_CFG_W-1:0] half_length;
    logic [THR_W-1:0]      edge_threshold;
    logic                  select_first;
    logic                  light_to_dark;
    logic [DEPTH_W-1:0]    depth_limit;

    // Line state.
    logic [SUM_W-1:0]         lane_sums [WIN_DEPTH];
    logic [POS_W-1:0]         line_pos;
    logic [POS_W-1:0]         best_pos;
    logic signed [DIFF_W-1:0] best_str;
    logic                     have_edge;
    logic                     cand_valid;
    logic [POS_W-1:0]         cand_pos;
    logic signed [DIFF_W-1:0] cand_str;
    logic [DEPTH_W-1:0]       lookahead_left;
    logic                     line_settled;

    initial
    begin
        results_owed   = 0;
        mismatches     = 0;
        edges_reported = 0;
    end

    function automatic void clear_line();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            lane_sums[i] = '0;
        end
        line_pos       = '0;
        best_pos       = '0;
        best_str       = '0;
        have_edge      = 1'b0;
        cand_valid     = 1'b0;
        cand_pos       = '0;
        cand_str       = '0;
        lookahead_left = '0;
        line_settled   = 1'b0;
    endfunction

    function automatic void write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BLUR_WIDTH:     blur_width     = data[BLUR_W-1:0];
            REG_HALF_LENGTH:    half_length    = data[HALF_CFG_W-1:0];
            REG_EDGE_THRESHOLD: edge_threshold = data[THR_W-1:0];
            REG_SELECT_FIRST:   select_first   = data[0];
            REG_LIGHT_TO_DARK:  light_to_dark  = data[0];
            REG_DEPTH_LIMIT:    depth_limit    = data[DEPTH_W-1:0];
            default:            ;
        endcase
    endfunction

    // Runs one accepted position through the filter and the selection logic.
    function automatic void scan_position();
        int pix [LANES];
        int w;
        int h;
        int lane_total;
        int diff;
        int thresh;
        int s;
        int best_signed;
        logic [POS_W-1:0] centre;
        edge_report_t rep;

        pix = '{int'(pixel_0), int'(pixel_1), int'(pixel_2), int'(pixel_3),
                int'(pixel_4), int'(pixel_5), int'(pixel_6), int'(pixel_7)};
        w = int'(blur_width);
        h = int'(half_length);
        if (w < 1) w = 1;
        if (w > LANES) w = LANES;
        if (h < 1) h = 1;
        if (h > MAX_HALF_LENGTH) h = MAX_HALF_LENGTH;

        lane_total = 0;
        for (int i = 0; i < w; i++)
        begin
            lane_total += pix[i];
        end
        for (int i = WIN_DEPTH - 1; i > 0; i--)
        begin
            lane_sums[i] = lane_sums[i-1];
        end
        lane_sums[0] = SUM_W'(lane_total);

        if (int'(line_pos) >= 2 * h)
        begin
            diff = 0;
            for (int i = 0; i < h; i++)
            begin
                diff += int'(lane_sums[i]) - int'(lane_sums[h + 1 + i]);
            end
            thresh = int'(edge_threshold) * w * h;
            centre = line_pos - POS_W'(h);
            s = light_to_dark ? -diff : diff;

            if (!select_first)
            begin
                best_signed = light_to_dark ? -int'(best_str) : int'(best_str);
                if (s > best_signed && s > 0 && s >= thresh)
                begin
                    best_str  = DIFF_W'(diff);
                    best_pos  = centre;
                    have_edge = 1'b1;
                end
            end
            else if (!line_settled)
            begin
                if (cand_valid)
                begin
                    // An opposite edge inside the lookahead throws the candidate away.
                    if (s < -thresh)
                    begin
                        cand_valid = 1'b0;
                    end
                    else
                    begin
                        lookahead_left = lookahead_left - 1'b1;
                        if (lookahead_left == '0)
                        begin
                            line_settled = 1'b1;
                            have_edge    = 1'b1;
                            best_pos     = cand_pos;
                            best_str     = cand_str;
                            cand_valid   = 1'b0;
                        end
                    end
                end
                else if (s > thresh)
                begin
                    if (depth_limit == '0)
                    begin
                        line_settled = 1'b1;
                        have_edge    = 1'b1;
                        best_pos     = centre;
                        best_str     = DIFF_W'(diff);
                    end
                    else
                    begin
                        cand_valid     = 1'b1;
                        cand_pos       = centre;
                        cand_str       = DIFF_W'(diff);
                        lookahead_left = depth_limit;
                    end
                end
            end
        end

        if (!last_in_line)
        begin
            if (int'(line_pos) < LINE_LENGTH - 1)
            begin
                line_pos = line_pos + 1'b1;
            end
        end
        else
        begin
            // A candidate still inside its lookahead when the line ends is accepted.
            if (cand_valid && !line_settled)
            begin
                have_edge = 1'b1;
                best_pos  = cand_pos;
                best_str  = cand_str;
            end
            rep.found    = have_edge;
            rep.position = have_edge ? best_pos : '0;
            rep.strength = have_edge ? best_str : '0;
            owed_reports.insert(owed_reports.size(), rep);
            clear_line();
        end
    endfunction

    function automatic void check_report();
        edge_report_t want;

        if (owed_reports.size() == 0)
        begin
            $error("report beat arrived with no line outstanding");
            mismatches++;
        end
        else
        begin
            want = owed_reports.pop_front();
            if (found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, found);
                mismatches++;
            end
            if (edge_position !== want.position)
            begin
                $error("edge_position: expected %0d, got %0d", want.position, edge_position);
                mismatches++;
            end
            if (edge_strength !== want.strength)
            begin
                $error("edge_strength: expected %0d, got %0d", want.strength, edge_strength);
                mismatches++;
            end
            if (found === 1'b1)
            begin
                edges_reported++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_width     = BLUR_RST;
            half_length    = HALF_RST;
            edge_threshold = THR_RST;
            select_first   = 1'b0;
            light_to_dark  = 1'b0;
            depth_limit    = DEPTH_RST;
            clear_line();
            owed_reports.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_report();
            end
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_reg_t'(cfg_index), cfg_data);
            end
            if (in_valid && in_ready)
            begin
                scan_position();
            end
        end
        results_owed = owed_reports.size();
    end

endmodule

FILE: bench/scanline_edge_point_finder_unit_tb.sv
// Testbench top of the scan-line edge point finder: stimulus, ready pressure and verdict.
`timescale 1ns / 1ps

module scanline_edge_point_finder_unit_tb;

    import sepf_pkg::*;

    // Roughly how many positions the random part feeds in.
    localparam int RANDOM_POSITIONS = 1300;
    // Extra pause after the last report, so that the pipeline is empty before the next step.
    localparam int LATENCY_SLACK    = 8;
    // Quiet cycles allowed before the run is declared hung. The longest legal quiet spell is a
    // long sender gap plus a long output stall plus a settling pause.
    localparam int WATCHDOG_LIMIT   = 2000;

    typedef enum int {
        PROF_FLAT,
        PROF_STEP,
        PROF_PULSE,
        PROF_NOISE
    } line_profile_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [PIX_W-1:0]         pixel [LANES];
    logic                     last_in_line;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     found;
    logic [POS_W-1:0]         edge_position;
    logic signed [DIFF_W-1:0] edge_strength;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_reg_t                 cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int results_owed;
    int mismatches;
    int edges_reported;

    // Bookkeeping for stimulus shaping and the summary.
    int positions_sent   = 0;
    int lines_sent       = 0;
    int settings_applied = 0;
    int active_lanes     = 5;
    int active_half      = 2;
    int ready_hold       = 0;
    int quiet_cycles     = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    scanline_edge_point_finder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_0       (pixel[0]),
        .pixel_1       (pixel[1]),
        .pixel_2       (pixel[2]),
        .pixel_3       (pixel[3]),
        .pixel_4       (pixel[4]),
        .pixel_5       (pixel[5]),
        .pixel_6       (pixel[6]),
        .pixel_7       (pixel[7]),
        .last_in_line  (last_in_line),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .edge_position (edge_position),
        .edge_strength (edge_strength),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    edge_report_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_0        (pixel[0]),
        .pixel_1        (pixel[1]),
        .pixel_2        (pixel[2]),
        .pixel_3        (pixel[3]),
        .pixel_4        (pixel[4]),
        .pixel_5        (pixel[5]),
        .pixel_6        (pixel[6]),
        .pixel_7        (pixel[7]),
        .last_in_line   (last_in_line),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .edge_position  (edge_position),
        .edge_strength  (edge_strength),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .results_owed   (results_owed),
        .mismatches     (mismatches),
        .edges_reported (edges_reported)
    );

    // Idle spell length: mostly none, often a short spell, now and then a long one.
    function automatic int gap_len();
        int r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // The report side alternates runs of readiness with stalls, so that back pressure lands
    // on every stage of the pipeline, including long stretches where it never stalls at all.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if ($urandom_range(0, 2) != 0)
        begin
            out_ready  <= 1'b1;
            ready_hold  = $urandom_range(1, 60);
        end
        else
        begin
            out_ready  <= 1'b0;
            ready_hold  = gap_len();
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d reports outstanding",
                         quiet_cycles, results_owed);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Sends one position. Lanes beyond the summed width carry random values, which the block
    // must ignore. A scrambled position has every lane random.
    task automatic send_position(input int level, input int noise, input bit scramble,
                                 input bit last, input bit steady);
        int idle;
        int v;

        idle = steady ? 0 : gap_len();
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (scramble || i >= active_lanes)
            begin
                v = $urandom_range(0, 255);
            end
            else
            begin
                v = level - noise + int'($urandom_range(0, 2 * noise));
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            pixel[i] <= PIX_W'(v);
        end
        last_in_line <= last;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        positions_sent++;
    endtask

    // Sends a whole line shaped by the profile. edge_at below zero picks the step at random.
    task automatic run_line(input int len, input line_profile_t profile, input bit steady,
                            input int edge_at);
        int lo;
        int hi;
        int rise;
        int fall;
        int noise;
        int level;

        lo = $urandom_range(0, 255);
        hi = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0)
        begin
            // Full-scale contrast in one direction or the other.
            lo = ($urandom_range(0, 1) == 0) ? 0 : 255;
            hi = 255 - lo;
        end
        rise  = (edge_at < 0) ? $urandom_range(0, len) : edge_at;
        fall  = rise + $urandom_range(1, 8);
        noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        for (int p = 0; p < len; p++)
        begin
            case (profile)
                PROF_STEP:  level = (p < rise) ? lo : hi;
                PROF_PULSE: level = (p >= rise && p < fall) ? hi : lo;
                default:    level = lo;
            endcase
            send_position(level, noise, profile == PROF_NOISE, p == len - 1, steady);
        end
        lines_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Registers change only on an idle block: the sender holds off until every report has
    // come back, which also gives the output side a chance to drain completely, and then waits
    // out the pipeline before touching the registers.
    task automatic set_config(input int blur, input int half, input int thr,
                              input int sel_first, input int dark, input int depth);
        in_valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (LATENCY_SLACK) @(negedge clk);
        write_reg(REG_BLUR_WIDTH, blur);
        write_reg(REG_HALF_LENGTH, half);
        write_reg(REG_EDGE_THRESHOLD, thr);
        write_reg(REG_SELECT_FIRST, sel_first);
        write_reg(REG_LIGHT_TO_DARK, dark);
        write_reg(REG_DEPTH_LIMIT, depth);
        cfg_valid <= 1'b0;
        active_lanes = (blur < 1) ? 1 : ((blur > LANES) ? LANES : blur);
        active_half  = (half < 1) ? 1 : ((half > MAX_HALF_LENGTH) ? MAX_HALF_LENGTH : half);
        settings_applied++;
    endtask

    initial
    begin
        int pattern [7];
        int random_start;
        int blur;
        int half;
        int thr;
        int depth;
        int lines_in_phase;
        int len;
        int r;
        line_profile_t profile;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        last_in_line = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BLUR_WIDTH;
        cfg_data     = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pixel[i] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, on the reset settings first. A line of a single bright position
        // has no complete window, so nothing is found.
        send_position(255, 0, 1'b0, 1'b1, 1'b0);
        // A clean dark-to-light step: found at the first centre of largest strength.
        for (int p = 0; p < 6; p++)
        begin
            send_position((p < 3) ? 0 : 255, 0, 1'b0, p == 5, 1'b0);
        end
        // A light-to-dark step is of the wrong polarity here.
        for (int p = 0; p < 6; p++)
        begin
            send_position((p < 3) ? 255 : 0, 0, 1'b0, p == 5, 1'b0);
        end
        lines_sent += 3;

        // Zero width and half length are taken as one; first mode on falling edges with
        // no lookahead and a zero threshold.
        set_config(0, 0, 0, 1, 1, 0);
        for (int p = 0; p < 5; p++)
        begin
            send_position((p < 2) ? 255 : 0, 0, 1'b0, p == 4, 1'b0);
        end
        // First mode with a short lookahead: the one-position pulse at the start cancels out in
        // the difference, and the second rise is taken, its candidate still inside the lookahead at line end.
        set_config(1, 1, 0, 1, 0, 2);
        pattern = '{0, 255, 0, 0, 0, 255, 255};
        for (int p = 0; p < 7; p++)
        begin
            send_position(pattern[p], 0, 1'b0, p == 6, 1'b0);
        end
        lines_sent += 2;

        // Random part: phases of a few lines each under one setting, mostly step and pulse
        // shaped lines so that edges are actually found, with noise lines and lines too
        // short for a complete window mixed in.
        random_start = positions_sent;
        while (positions_sent - random_start < RANDOM_POSITIONS)
        begin
            case ($urandom_range(0, 5))
                0:       blur = 0;
                1:       blur = 1;
                2:       blur = 8;
                3:       blur = 15;
                default: blur = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 5))
                0:       half = 0;
                1:       half = 1;
                2:       half = 8;
                3:       half = 15;
                default: half = $urandom_range(1, 8);
            endcase
            r = $urandom_range(0, 9);
            thr = (r == 0) ? 0 : ((r == 1) ? 255 : $urandom_range(0, 60));
            r = $urandom_range(0, 9);
            if (r < 3)
                depth = 0;
            else if (r == 3)
                depth = 2047;
            else
                depth = $urandom_range(1, 12);
            set_config(blur, half, thr, $urandom_range(0, 1), $urandom_range(0, 1), depth);

            lines_in_phase = $urandom_range(1, 6);
            repeat (lines_in_phase)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = $urandom_range(1, 2 * active_half);
                else if (r < 92)
                    len = $urandom_range(2 * active_half + 1, 2 * active_half + 30);
                else
                    len = $urandom_range(60, 160);
                r = $urandom_range(0, 99);
                if (r < 35)
                    profile = PROF_STEP;
                else if (r < 65)
                    profile = PROF_PULSE;
                else if (r < 75)
                    profile = PROF_FLAT;
                else
                    profile = PROF_NOISE;
                run_line(len, profile, $urandom_range(0, 3) == 0, -1);
            end
        end

        in_valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (LATENCY_SLACK) @(negedge clk);

        $display("Run covered %0d positions in %0d lines over %0d register settings;",
                 positions_sent, lines_sent, settings_applied + 1);
        $display("%0d lines reported an edge, %0d field mismatches seen.",
                 edges_reported, mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
